// File: rtl/mrwr_pkg.sv
// shared constants and types for the miller-rabin round unit
package mrwr_pkg;
   localparam int WIDTH = 32;
   localparam int IDX_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      VERDICT_PASS      = 2'd0,
      VERDICT_COMPOSITE = 2'd1,
      VERDICT_REJECT    = 2'd2,
      VERDICT_TWO       = 2'd3
   } verdict_type;
endpackage

// File: rtl/mrwr_cell.sv
// one step of the interleaved modular multiply: r <- 2r + bit*y mod n
module mrwr_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   input  mrwr_pkg::word_type  r_in,
   input  logic                mult_bit,
   input  mrwr_pkg::word_type  y,
   input  mrwr_pkg::word_type  n,
   output logic                valid_out,
   output mrwr_pkg::word_type  r_out
);
   import mrwr_pkg::*;

   logic              valid_ff;
   word_type          r_ff;
   word_type          r_in_val;
   logic [WIDTH:0]    dbl;
   logic [WIDTH:0]    red1;
   logic [WIDTH:0]    sum;
   logic [WIDTH:0]    n_ext;

   always_comb begin
      n_ext = {1'b0, n};
      dbl   = {r_in, 1'b0};
      red1  = (dbl >= n_ext) ? dbl - n_ext : dbl;
      sum   = red1 + (mult_bit ? {1'b0, y} : '0);
      r_in_val = (sum >= n_ext) ? WIDTH'(sum - n_ext) : WIDTH'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      r_ff <= r_in_val;
   end

   assign valid_out = valid_ff;
   assign r_out     = r_ff;
endmodule

// File: rtl/miller_rabin_witness_round_unit.sv
// top level: one miller-rabin round per candidate and base
// Takes one candidate and base per beat and returns one verdict beat: 0 passes the round,
// 1 base proves the candidate composite, 2 candidate even or at most one, 3 candidate is two.
// Items are handled one at a time; req_stall stays high while an item is being worked on.
// Every modular product runs through a row of WIDTH cells, one multiplier bit per cell.
// A round costs one product to reduce the base, one square per bit of d plus one multiply
// per set bit of d, and up to b further squares, plus one split step per factor of two
// stripped from candidate-1. Rejected candidates and the candidate two skip the products
// and go straight to the verdict.
module miller_rabin_witness_round_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mrwr_pkg::word_type  req_candidate,
   input  mrwr_pkg::word_type  req_base,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_verdict
);
   import mrwr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SPLIT = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_CHK   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // what the running product is for
   typedef enum logic [1:0] {
      PH_RED = 2'd0,
      PH_SQ  = 2'd1,
      PH_ML  = 2'd2,
      PH_FIN = 2'd3
   } phase_type;

   state_type   state_ff,  state_in;
   phase_type   phase_ff,  phase_in;
   word_type    n_ff,      n_in;
   word_type    a_ff,      a_in;
   word_type    d_ff,      d_in;
   word_type    g_ff,      g_in;
   word_type    acc_ff,    acc_in;
   word_type    mx_ff,     mx_in;
   word_type    my_ff,     my_in;
   idx_type     b_ff,      b_in;
   idx_type     cnt_ff,    cnt_in;
   idx_type     idx_ff,    idx_in;
   logic        start_ff,  start_in;
   verdict_type res_ff,    res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_verdict_ff, rsp_verdict_in;

   // cell row
   logic        v_chain [0:WIDTH];
   word_type    r_chain [0:WIDTH];

   assign v_chain[0] = start_ff;
   assign r_chain[0] = '0;

   genvar k;
   generate
      for (k = 0; k < WIDTH; k++) begin : g_cell
         mrwr_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .valid_in  (v_chain[k]),
            .r_in      (r_chain[k]),
            .mult_bit  (mx_ff[WIDTH-1-k]),
            .y         (my_ff),
            .n         (n_ff),
            .valid_out (v_chain[k+1]),
            .r_out     (r_chain[k+1])
         );
      end
   endgenerate

   logic     req_take;
   logic     rsp_free;
   word_type prod;
   word_type n_minus_1;

   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign prod      = r_chain[WIDTH];
   assign n_minus_1 = n_ff - word_type'(1);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      g_in     = g_ff;
      acc_in   = acc_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      start_in = 1'b0;
      res_in   = res_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in   = req_candidate;
               a_in   = req_base;
               d_in   = req_candidate - word_type'(1);
               b_in   = '0;
               if (req_candidate == word_type'(2)) begin
                  res_in   = VERDICT_TWO;
                  state_in = ST_DONE;
               end else if (!req_candidate[0] || req_candidate <= word_type'(1)) begin
                  res_in   = VERDICT_REJECT;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               b_in = b_ff + idx_type'(1);
            end else begin
               // base mod n by horner over the base bits with y = 1
               mx_in    = a_ff;
               my_in    = word_type'(1);
               phase_in = PH_RED;
               start_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (v_chain[WIDTH]) begin
               case (phase_ff)
                  PH_RED: begin
                     g_in     = prod;
                     acc_in   = word_type'(1);
                     idx_in   = idx_type'(WIDTH-1);
                     mx_in    = word_type'(1);
                     my_in    = word_type'(1);
                     phase_in = PH_SQ;
                     start_in = 1'b1;
                  end
                  PH_SQ, PH_ML: begin
                     acc_in = prod;
                     if (phase_ff == PH_SQ && d_ff[idx_ff]) begin
                        mx_in    = prod;
                        my_in    = g_ff;
                        phase_in = PH_ML;
                        start_in = 1'b1;
                     end else if (idx_ff == '0) begin
                        // exponent done: x == 1 passes at once
                        cnt_in = '0;
                        if (prod == word_type'(1)) begin
                           res_in   = VERDICT_PASS;
                           state_in = ST_DONE;
                        end else begin
                           state_in = ST_CHK;
                        end
                     end else begin
                        idx_in   = idx_ff - idx_type'(1);
                        mx_in    = prod;
                        my_in    = prod;
                        phase_in = PH_SQ;
                        start_in = 1'b1;
                     end
                  end
                  default: begin
                     acc_in   = prod;
                     state_in = ST_CHK;
                  end
               endcase
            end
         end
         ST_CHK: begin
            if (cnt_ff == b_ff) begin
               res_in   = VERDICT_COMPOSITE;
               state_in = ST_DONE;
            end else if (acc_ff == n_minus_1) begin
               res_in   = VERDICT_PASS;
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + idx_type'(1);
               mx_in    = acc_ff;
               my_in    = acc_ff;
               phase_in = PH_FIN;
               start_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            // hand the verdict to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff       <= phase_in;
      n_ff           <= n_in;
      a_ff           <= a_in;
      d_ff           <= d_in;
      g_ff           <= g_in;
      acc_ff         <= acc_in;
      mx_ff          <= mx_in;
      my_ff          <= my_in;
      b_ff           <= b_in;
      cnt_ff         <= cnt_in;
      idx_ff         <= idx_in;
      res_ff         <= res_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
endmodule

// File: rtl/mrwr_checker.sv
// port-level checks for the miller-rabin round unit and their binding
module mrwr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_verdict
);
   // a taken item keeps the unit busy on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("unit not busy after taking an item");

   // a verdict only appears while an item is in flight
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("verdict without an item in flight");

   // a stalled verdict beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict))
      else $error("stalled verdict changed");
endmodule

bind miller_rabin_witness_round_unit mrwr_checker u_mrwr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_verdict (rsp_verdict)
);

// File: verif/tb.sv
// testbench for the miller-rabin round unit: random and directed candidates checked by a scoreboard
`timescale 1ns / 100ps

module tb;
   import mrwr_pkg::*;

   // verdict store: predicts one verdict per accepted request and checks returned beats
   class verdict_board;
      verdict_type pending[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      // exact modular product, operands below 2^32
      function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
         return (x * y) % n;
      endfunction

      function automatic verdict_type predict_round(word_type cand, word_type wit);
         logic [63:0] n, d, x, g, e;
         int twos;
         verdict_type v;
         n = cand;
         if (n == 2) return VERDICT_TWO;
         if (n[0] == 1'b0 || n <= 1) return VERDICT_REJECT;
         d = n - 1;
         twos = 0;
         while (d[0] == 1'b0) begin
            d = d >> 1;
            twos++;
         end
         x = 1;
         g = wit % n;
         e = d;
         while (e != 0) begin
            if (e[0]) x = mulmod(x, g, n);
            g = mulmod(g, g, n);
            e = e >> 1;
         end
         v = VERDICT_COMPOSITE;
         if (x == 1) v = VERDICT_PASS;
         else begin
            for (int i = 0; i < twos; i++) begin
               if (x == n - 1) begin
                  v = VERDICT_PASS;
                  break;
               end
               x = mulmod(x, x, n);
            end
         end
         return v;
      endfunction

      function void note_request(word_type cand, word_type wit);
         pending.push_back(predict_round(cand, wit));
      endfunction

      function void check_verdict(logic [1:0] got);
         verdict_type want;
         if (pending.size() == 0) begin
            $error("verdict beat with nothing pending: verdict=%0d", got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $error("verdict mismatch: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction
   endclass

   localparam int RANDOM_ITEMS = 245;
   localparam int IDLE_LIMIT   = 40000;   // covers one item's work plus stall bursts

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   word_type   req_candidate;
   word_type   req_base;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_verdict;

   verdict_board board;
   bit   calm_phase;         // no idling in the final part
   bit   hold_rsp;           // long receiver hold-off request
   int   idle_cycles;

   miller_rabin_witness_round_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .req_base      (req_base),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one request beat and hold it until accepted; valid drops only on idling
   task automatic send_round(word_type cand, word_type wit);
      int gap;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= cand;
      req_base      <= wit;
      do @(posedge clock); while (req_stall);
      board.note_request(cand, wit);
      @(negedge clock);
   endtask

   // sender pause until every expected verdict has arrived
   task automatic drain_all();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // random candidate, mostly odd and mostly small so that rounds stay varied
   function automatic word_type pick_candidate();
      word_type c;
      case ($urandom_range(0, 9))
         0: c = $urandom();                         // any value, even ones too
         1, 2: c = $urandom() | 32'h8000_0001;      // large odd
         3: c = $urandom_range(0, 16);
         default: c = ($urandom() >> $urandom_range(8, 28)) | 1;
      endcase
      return c;
   endfunction

   function automatic word_type pick_base(word_type cand);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return cand;
         2: return cand - 1;
         3: return 1;
         default: return $urandom();
      endcase
   endfunction

   // directed corners then random rounds
   initial begin
      word_type c;
      board         = new();
      calm_phase    = 1'b0;
      hold_rsp      = 1'b0;
      req_valid     = 1'b0;
      req_candidate = '0;
      req_base      = '0;
      reset         = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // rejected and special candidates
      send_round(32'd0, 32'd5);
      send_round(32'd1, 32'hFFFF_FFFF);
      send_round(32'd2, 32'd7);
      send_round(32'd4, 32'd3);
      send_round(32'hFFFF_FFFE, 32'd3);
      // base congruent to 0, 1 and candidate-1
      send_round(32'd97, 32'd0);
      send_round(32'd97, 32'd97);
      send_round(32'd97, 32'd1);
      send_round(32'd97, 32'd96);
      // small primes and composites, a strong pseudoprime and all-ones fields
      send_round(32'd3, 32'd2);
      send_round(32'd561, 32'd2);
      send_round(32'd2047, 32'd2);
      send_round(32'd221, 32'd174);
      send_round(32'hFFFF_FFFB, 32'hFFFF_FFFF);
      send_round(32'hFFFF_FFFF, 32'hAAAA_AAAA);
      send_round(32'h8000_0001, 32'h5555_5555);
      send_round(32'd4294967291, 32'd12345);
      drain_all();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40) hold_rsp = 1'b1;       // receiver stops for a long stretch
         if (i == 120) drain_all();
         if (i == RANDOM_ITEMS - 30) calm_phase = 1'b1;
         c = pick_candidate();
         send_round(c, pick_base(c));
      end
      drain_all();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off, no stalls when calm
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (6000) @(negedge clock);
         end else if (!calm_phase && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end else begin
            n = $urandom_range(1, 8);
            rsp_stall <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   // result check and watchdog on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_verdict(rsp_verdict);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else idle_cycles <= idle_cycles + 1;
      end
   end
endmodule
